// File: src/flag_deframer_bit_destuffer_assert.svh
// Assertion macros for the deframer.
`ifndef FLAG_DEFRAMER_BIT_DESTUFFER_ASSERT_SVH
`define FLAG_DEFRAMER_BIT_DESTUFFER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FDBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fdbd: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FDBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fdbd: next-cycle check failed");

`endif

// File: src/fdbd_pkg.sv
`default_nettype none

package fdbd_pkg;

  localparam int unsigned FrameBitsW = 16;
  localparam int unsigned MinLenW    = 8;

  localparam logic [7:0]         FlagPattern    = 8'h7E;
  localparam logic [2:0]         StuffRun       = 3'd5;
  localparam logic [2:0]         SkipStart      = 3'd7;
  localparam logic [3:0]         WindowBits     = 4'd8;
  localparam logic [MinLenW-1:0] MinLengthReset = 8'd32;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindLong    = 2'd1;
  localparam logic [1:0] KindShort   = 2'd2;

  typedef enum logic [3:0] {
    MODE_HUNT  = 4'b0001,
    MODE_SKIP  = 4'b0010,
    MODE_FRAME = 4'b0100,
    MODE_DROP  = 4'b1000
  } mode_e;

endpackage

`default_nettype wire

// File: src/flag_deframer_bit_destuffer.sv
// Flag deframer with bit destuffing.
// Input channel: one line bit per item on line_bit_i, qualified by in_valid_i and
// taken when in_stall_o is low. Output channel: one result per item at most, on
// payload_bit_o, kind_o and frame_bits_o, qualified by out_valid_o and taken when
// out_stall_i is low. kind_o is 0 for a destuffed data bit, 1 for a frame end
// carrying more than min_length bits, 2 for a frame end that is too short.
// Configuration: cfg_we_i writes min_length from cfg_wdata_i; write only when idle.
// A result appears on the output register in the cycle after its item is taken.
// Throughput: one item per cycle while no stall is held, set by the single state
// update and the output register, which loads while the previous result is taken.
// The first seven items after reset only fill the look-ahead window and give no
// result. Hunted flags, stuffed bits and skipped flag bits give none either; a
// closing flag gives only the frame-end result. Reset clears the window, returns
// to flag hunting and sets min_length to 32. While the receiver stalls a held
// result, in_stall_o is raised and the result and all state hold.
`default_nettype none

module flag_deframer_bit_destuffer #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [fdbd_pkg::MinLenW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       line_bit_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            payload_bit_o,
  output logic [1:0]                      kind_o,
  output logic [fdbd_pkg::FrameBitsW-1:0] frame_bits_o
);
  import fdbd_pkg::*;

  logic [MinLenW-1:0]      min_length_q;
  logic [7:0]              window_q, window_d;
  logic [3:0]              fill_q, fill_d;
  mode_e                   mode_q, mode_d;
  logic [2:0]              skip_left_q, skip_left_d;
  logic [2:0]              ones_run_q, ones_run_d;
  logic [LENGTH_WIDTH-1:0] frame_length_q, frame_length_d;

  logic                    out_valid_q, out_valid_d;
  logic                    payload_bit_q, payload_bit_d;
  logic [1:0]              kind_q, kind_d;
  logic [FrameBitsW-1:0]   frame_bits_q, frame_bits_d;

  logic                    in_acc;
  logic                    res_valid;
  logic                    cur_bit;
  logic [FrameBitsW-1:0]   shown;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  if (LENGTH_WIDTH > FrameBitsW) begin : g_sat
    assign shown = (|frame_length_q[LENGTH_WIDTH-1:FrameBitsW]) ? '1
                                                                : frame_length_q[FrameBitsW-1:0];
  end else begin : g_ext
    assign shown = FrameBitsW'(frame_length_q);
  end

  always_comb begin
    window_d       = {window_q[6:0], line_bit_i};
    fill_d         = (fill_q < WindowBits) ? fill_q + 4'd1 : fill_q;
    mode_d         = mode_q;
    skip_left_d    = skip_left_q;
    ones_run_d     = ones_run_q;
    frame_length_d = frame_length_q;
    cur_bit        = window_d[7];
    res_valid      = 1'b0;
    payload_bit_d  = 1'b0;
    kind_d         = KindPayload;
    frame_bits_d   = '0;
    if (fill_d == WindowBits) begin
      unique case (mode_q)
        MODE_HUNT: begin
          if (window_d == FlagPattern) begin
            mode_d      = MODE_SKIP;
            skip_left_d = SkipStart;
          end
        end
        MODE_SKIP: begin
          skip_left_d = skip_left_q - 3'd1;
          if (skip_left_q <= 3'd1) begin
            skip_left_d    = '0;
            mode_d         = MODE_FRAME;
            ones_run_d     = '0;
            frame_length_d = '0;
          end
        end
        MODE_DROP: begin
          mode_d = MODE_FRAME;
        end
        MODE_FRAME: begin
          res_valid = 1'b1;
          if (window_d == FlagPattern) begin
            kind_d       = (frame_length_q > LENGTH_WIDTH'(min_length_q)) ? KindLong
                                                                           : KindShort;
            frame_bits_d = shown;
            mode_d       = MODE_HUNT;
            ones_run_d   = '0;
          end else begin
            payload_bit_d = cur_bit;
            ones_run_d    = cur_bit ? ones_run_q + 3'd1 : '0;
            if (frame_length_q != '1) begin
              frame_length_d = frame_length_q + 1'b1;
            end
            if (ones_run_d >= StuffRun) begin
              ones_run_d = '0;
              mode_d     = MODE_DROP;
            end
          end
        end
        default: begin
          mode_d = MODE_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q   <= MinLengthReset;
      window_q       <= '0;
      fill_q         <= '0;
      mode_q         <= MODE_HUNT;
      skip_left_q    <= '0;
      ones_run_q     <= '0;
      frame_length_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_length_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        window_q       <= window_d;
        fill_q         <= fill_d;
        mode_q         <= mode_d;
        skip_left_q    <= skip_left_d;
        ones_run_q     <= ones_run_d;
        frame_length_q <= frame_length_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      payload_bit_q <= payload_bit_d;
      kind_q        <= kind_d;
      frame_bits_q  <= frame_bits_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign payload_bit_o = payload_bit_q;
  assign kind_o        = kind_q;
  assign frame_bits_o  = frame_bits_q;

`include "flag_deframer_bit_destuffer_assert.svh"

  `FDBD_ASSERT_NOW(a_skip_nonzero, mode_q == MODE_SKIP, skip_left_q != 3'd0)
  `FDBD_ASSERT_NEXT(a_drop_silent, in_acc && mode_q == MODE_DROP, !out_valid_o)
  `FDBD_ASSERT_NEXT(a_close_marker, in_acc && mode_q == MODE_FRAME && mode_d == MODE_HUNT,
                    out_valid_o && kind_o != KindPayload)

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fdbd_pkg::*;

  typedef struct packed {
    logic                  payload;
    logic [1:0]            kind;
    logic [FrameBitsW-1:0] bits;
  } deframe_result_t;

  class deframer_scoreboard_t;
    logic [7:0]            window;
    int unsigned           fill;
    mode_e                 mode;
    logic [2:0]            skip_left;
    logic [2:0]            ones_run;
    logic [FrameBitsW-1:0] frame_len;
    logic [MinLenW-1:0]    min_len;
    deframe_result_t       expected_results[$];
    int unsigned           errors;
    int unsigned           n_data;
    int unsigned           n_long;
    int unsigned           n_short;

    function new();
      window    = '0;
      fill      = 0;
      mode      = MODE_HUNT;
      skip_left = '0;
      ones_run  = '0;
      frame_len = '0;
      min_len   = MinLengthReset;
      errors    = 0;
      n_data    = 0;
      n_long    = 0;
      n_short   = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_line_bit(logic b);
      logic            cur;
      deframe_result_t r;
      window = {window[6:0], b};
      if (fill < WindowBits) fill++;
      if (fill < WindowBits) return;
      cur = window[7];
      case (mode)
        MODE_HUNT: begin
          if (window == FlagPattern) begin
            mode      = MODE_SKIP;
            skip_left = SkipStart;
          end
          return;
        end
        MODE_SKIP: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) begin
            mode      = MODE_FRAME;
            ones_run  = '0;
            frame_len = '0;
          end
          return;
        end
        MODE_DROP: begin
          mode = MODE_FRAME;
          return;
        end
        default: ;
      endcase
      if (window == FlagPattern) begin
        r.payload = 1'b0;
        r.kind    = (frame_len > min_len) ? KindLong : KindShort;
        r.bits    = frame_len;
        mode      = MODE_HUNT;
        ones_run  = '0;
        if (r.kind == KindLong) n_long++;
        else n_short++;
        expected_results.push_back(r);
        return;
      end
      ones_run = cur ? ones_run + 3'd1 : 3'd0;
      if (frame_len != '1) frame_len++;
      if (ones_run >= StuffRun) begin
        ones_run = '0;
        mode     = MODE_DROP;
      end
      r.payload = cur;
      r.kind    = KindPayload;
      r.bits    = '0;
      n_data++;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic p, logic [1:0] k, logic [FrameBitsW-1:0] fb);
      deframe_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with none expected: payload_bit %0d kind %0d frame_bits %0d",
               p, k, fb);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (p !== e.payload) begin
        $error("payload_bit expected %0d actual %0d", e.payload, p);
        errors++;
      end
      if (k !== e.kind) begin
        $error("kind expected %0d actual %0d", e.kind, k);
        errors++;
      end
      if (fb !== e.bits) begin
        $error("frame_bits expected %0d actual %0d", e.bits, fb);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [MinLenW-1:0]    cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  line_bit_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  payload_bit_o;
  logic [1:0]            kind_o;
  logic [FrameBitsW-1:0] frame_bits_o;

  deframer_scoreboard_t sb;
  logic                 line_q[$];
  int unsigned          send_idle_pct;
  int unsigned          stall_pct;
  int unsigned          n_items;
  int unsigned          quiet_cycles;

  flag_deframer_bit_destuffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .line_bit_i    (line_bit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .payload_bit_o (payload_bit_o),
    .kind_o        (kind_o),
    .frame_bits_o  (frame_bits_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(payload_bit_o, kind_o, frame_bits_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_line_bit(line_bit_i);
        n_items++;
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic void push_flag();
    for (int i = 7; i >= 0; i--) line_q.push_back(FlagPattern[i]);
  endfunction

  // Stuff a zero after every run of five ones.
  function automatic void push_payload(int unsigned n, int unsigned ones_pct);
    int unsigned run;
    logic        b;
    run = 0;
    repeat (n) begin
      b = ($urandom_range(0, 99) < ones_pct);
      line_q.push_back(b);
      run = b ? run + 1 : 0;
      if (run == 5) begin
        line_q.push_back(1'b0);
        run = 0;
      end
    end
  endfunction

  function automatic void push_noise(int unsigned n, int unsigned ones_pct);
    repeat (n) line_q.push_back($urandom_range(0, 99) < ones_pct);
  endfunction

  task automatic send_line();
    logic b;
    while (line_q.size() != 0) begin
      b = line_q.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      line_bit_i <= b;
      do @(posedge clk_i); while (in_stall_o);
      @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_min_length(logic [MinLenW-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.min_len = v;
  endtask

  task automatic random_phase(int unsigned idle_in, int unsigned stall_in,
                              logic [MinLenW-1:0] min_len);
    int unsigned pick;
    int unsigned len;
    wait_idle();
    write_min_length(min_len);
    send_idle_pct = idle_in;
    stall_pct     = stall_in;
    while (line_q.size() < 120) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
        if ($urandom_range(0, 3) == 0) push_flag();
        push_flag();
        push_payload(len, $urandom_range(30, 90));
        push_flag();
      end else if (pick < 85) begin
        push_noise($urandom_range(1, 20), 50);
      end else begin
        push_flag();
        push_noise($urandom_range(1, 30), 75);
        push_flag();
      end
    end
    send_line();
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    line_bit_i    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    n_items       = 0;
    quiet_cycles  = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Open on the first full window, then a stuffed one and a plain run.
    push_flag();
    line_q.push_back(1'b1);
    line_q.push_back(1'b1);
    line_q.push_back(1'b1);
    line_q.push_back(1'b1);
    line_q.push_back(1'b1);
    line_q.push_back(1'b1);
    line_q.push_back(1'b0);
    line_q.push_back(1'b0);
    line_q.push_back(1'b1);
    push_flag();
    send_line();

    wait_idle();
    write_min_length(8'd0);
    push_flag();
    push_flag();
    push_flag();
    push_payload(1, 50);
    push_flag();
    push_flag();
    push_payload(40, 50);
    push_flag();
    send_line();

    wait_idle();
    write_min_length(8'd255);
    push_flag();
    push_payload(30, 60);
    push_flag();
    send_line();

    wait_idle();
    write_min_length(8'd24);
    push_flag();
    push_payload(24, 60);
    push_flag();
    push_flag();
    push_payload(25, 60);
    push_flag();
    send_line();

    random_phase(0, 0, MinLenW'($urandom_range(0, 40)));
    random_phase(55, 0, MinLenW'($urandom_range(0, 40)));
    random_phase(0, 55, MinLenW'($urandom_range(0, 40)));
    random_phase(38, 38, MinLenW'($urandom_range(0, 40)));

    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d line bits through hunting, stuffing and length threshold cases",
             n_items);
    $display("Checked %0d data bits, %0d long and %0d short frame ends",
             sb.n_data, sb.n_long, sb.n_short);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/fdbd_pkg.sv
src/flag_deframer_bit_destuffer.sv
verif/testbench.sv
